[rtl/core/gtjs_pkg.sv]
// Shared types, codes and defaults for the generation-tagged job slot table.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package gtjs_pkg;

  localparam int CAPACITY_DEF      = 16;
  localparam int PAYLOAD_WIDTH_DEF = 64;

  // handle = generation << GEN_SHIFT | slot
  localparam int GEN_SHIFT = 8;
  localparam int GEN_BITS  = 64 - GEN_SHIFT;

  localparam logic [1:0] FUNC_STORE   = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP  = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;
  localparam logic [1:0] FUNC_INVAL   = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] payload_in;
    logic [63:0] handle_in;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] handle_out;
    logic [63:0] payload_out;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture request, issue table read
    logic exec;   // compare, update state, register result
  } cmd_t;

endpackage

`default_nettype wire

[rtl/core/generation_tagged_job_slot_table_top.sv]
// Each operation runs in two steps, and busy keeps a new request out until the
// last one is through: the accepting edge reads the slot memories at the
// request's slot, then the execute state compares, updates the table and registers the result.
// Reset (rst, synchronous): valid marks cleared, slot pointer 0, generation 1;
// slot memory contents are not cleared and are only read behind a valid mark.
// Results are shown for one cycle on done; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module generation_tagged_job_slot_table_top #(
  parameter int CAPACITY      = gtjs_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_WIDTH = gtjs_pkg::PAYLOAD_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire gtjs_pkg::req_t req,
  output logic                done,
  output gtjs_pkg::rsp_t      rsp
);

  gtjs_pkg::cmd_t cmd;

  gtjs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  gtjs_datapath #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

`default_nettype wire

[rtl/core/gtjs_ctrl.sv]
// Controller for the job slot table: two-state sequencer and result strobe.
// Depends on gtjs_pkg (cmd_t).
`timescale 1ns / 1ps
`default_nettype none

module gtjs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  output logic               done,
  output gtjs_pkg::cmd_t     cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_EXEC;
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_EXEC);
    end
  end

  assign busy     = (state == ST_EXEC);
  assign cmd.load = start && (state == ST_IDLE);
  assign cmd.exec = (state == ST_EXEC);

endmodule

`default_nettype wire

[rtl/core/gtjs_datapath.sv]
// Datapath for the job slot table: slot memories, valid marks, slot pointer,
// generation counter and result register. Depends on gtjs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gtjs_datapath #(
  parameter int CAPACITY      = gtjs_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_WIDTH = gtjs_pkg::PAYLOAD_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire gtjs_pkg::cmd_t cmd,
  input  wire gtjs_pkg::req_t req,
  output gtjs_pkg::rsp_t      rsp
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int GB    = gtjs_pkg::GEN_BITS;
  localparam int GS    = gtjs_pkg::GEN_SHIFT;

  // slot memories; slot index is implicit, so only the generation bits are kept
  logic [GB-1:0]            gen_mem [CAPACITY];
  logic [PAYLOAD_WIDTH-1:0] pay_mem [CAPACITY];
  logic [GB-1:0]            rd_gen;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;

  logic [CAPACITY-1:0] valid;
  logic [IDX_W-1:0]    ptr;
  logic [63:0]         gen;

  // captured request
  logic [1:0]               func;
  logic [PAYLOAD_WIDTH-1:0] payload;
  logic [63:0]              handle;
  logic                     in_range;
  logic [IDX_W-1:0]         slot;

  logic             req_in_range;
  logic [IDX_W-1:0] req_slot;
  logic             hit;
  logic [63:0]      gen_inc;
  logic [63:0]      gen_next;
  logic [IDX_W-1:0] ptr_next;
  logic             mem_we;
  gtjs_pkg::rsp_t   rsp_next;

  assign req_in_range = ({1'b0, req.handle_in[GS-1:0]} < 9'(CAPACITY));
  assign req_slot     = req_in_range ? req.handle_in[IDX_W-1:0] : '0;

  assign gen_inc  = gen + 64'd1;
  assign gen_next = (gen_inc == 64'd0) ? 64'd1 : gen_inc;
  assign ptr_next = (ptr == IDX_W'(CAPACITY - 1)) ? '0 : ptr + IDX_W'(1);

  assign hit = (handle != 64'd0) && in_range && valid[slot] &&
               (rd_gen == handle[63:GS]);

  assign mem_we = cmd.exec && (func == gtjs_pkg::FUNC_STORE);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func     <= req.func;
      payload  <= req.payload_in[PAYLOAD_WIDTH-1:0];
      handle   <= req.handle_in;
      in_range <= req_in_range;
      slot     <= req_slot;
      rd_gen   <= gen_mem[req_slot];
      rd_pay   <= pay_mem[req_slot];
    end
    if (mem_we) begin
      gen_mem[ptr] <= gen[GB-1:0];
      pay_mem[ptr] <= payload;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      ptr   <= '0;
      gen   <= 64'd1;
    end else if (cmd.exec) begin
      case (func)
        gtjs_pkg::FUNC_STORE: begin
          valid[ptr] <= 1'b1;
          ptr        <= ptr_next;
          gen        <= gen_next;
        end
        gtjs_pkg::FUNC_RELEASE: begin
          if (hit) valid[slot] <= 1'b0;
        end
        gtjs_pkg::FUNC_INVAL: begin
          valid <= '0;
          ptr   <= '0;
          gen   <= gen_next;
        end
        default: ;
      endcase
    end
  end

  // result
  always_comb begin
    rsp_next = '0;
    case (func)
      gtjs_pkg::FUNC_STORE: begin
        rsp_next.ok         = 1'b1;
        rsp_next.handle_out = {gen[GB-1:0], GS'(ptr)};
      end
      gtjs_pkg::FUNC_LOOKUP: begin
        rsp_next.ok = hit;
        if (hit) rsp_next.payload_out = 64'(rd_pay);
      end
      gtjs_pkg::FUNC_RELEASE: begin
        rsp_next.ok = hit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/gtjs_checker.sv]
// Port-level checks for the job slot table, bound to the top level.
// Depends on gtjs_pkg and generation_tagged_job_slot_table_top.
`timescale 1ns / 1ps
`default_nettype none

module gtjs_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire gtjs_pkg::req_t req,
  input wire logic           done,
  input wire gtjs_pkg::rsp_t rsp
);

  // an accepted transfer locks out the next one for a cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("result not delivered two cycles after accept");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_handle_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.handle_out != 64'd0)) |-> rsp.ok)
    else $error("nonzero handle on a failed result");

  a_inval_no_ok: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.func == gtjs_pkg::FUNC_INVAL)) |=> ##1 (done && !rsp.ok))
    else $error("invalidate-all reported ok");

endmodule

bind generation_tagged_job_slot_table_top gtjs_checker u_gtjs_checker (.*);

`default_nettype wire

[tb/generation_tagged_job_slot_table_top_test.sv]
// Self-checking testbench for the generation-tagged job slot table: queued
// store/lookup/release/invalidate traffic, checked against an in-bench table model.
// Depends on gtjs_pkg and generation_tagged_job_slot_table_top.
`timescale 1ns / 1ps

module generation_tagged_job_slot_table_top_test;

  localparam int CAPACITY   = gtjs_pkg::CAPACITY_DEF;
  localparam int GEN_SHIFT  = gtjs_pkg::GEN_SHIFT;
  localparam int RAND_OPS   = 1600;
  localparam int POOL_DEPTH = 48;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  gtjs_pkg::req_t req = '0;
  logic busy;
  logic done;
  gtjs_pkg::rsp_t rsp;

  generation_tagged_job_slot_table_top u_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Table model, advanced once per accepted request
  logic        slot_live [CAPACITY];
  logic [63:0] slot_handle [CAPACITY];
  logic [63:0] slot_payload [CAPACITY];
  int          store_slot = 0;
  logic [63:0] gen_count = 64'd1;

  // Request plan built ahead of time; handles it will produce are tracked
  gtjs_pkg::req_t job_q[$];
  logic [63:0]    recent_handles[$];
  int             plan_slot = 0;
  logic [63:0]    plan_gen = 64'd1;
  int             planned_ops = 0;

  gtjs_pkg::rsp_t awaited_rsps[$];
  int             accepted_ops = 0;
  int             errors = 0;

  initial begin
    for (int i = 0; i < CAPACITY; i++) begin
      slot_live[i] = 1'b0;
    end
  end

  function automatic logic [63:0] step_gen(logic [63:0] g);
    logic [63:0] n;
    n = g + 64'd1;
    return (n == 64'd0) ? 64'd1 : n;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic gtjs_pkg::rsp_t table_op(gtjs_pkg::req_t r);
    gtjs_pkg::rsp_t o;
    int   s;
    logic hit;
    o = '0;
    s = int'(r.handle_in[7:0]);
    hit = (r.handle_in != 64'd0) && (s < CAPACITY);
    if (hit) begin
      hit = slot_live[s] && (slot_handle[s] == r.handle_in);
    end
    case (r.func)
      gtjs_pkg::FUNC_STORE: begin
        o.ok = 1'b1;
        o.handle_out = (gen_count << GEN_SHIFT) | 64'(store_slot);
        slot_live[store_slot] = 1'b1;
        slot_handle[store_slot] = o.handle_out;
        slot_payload[store_slot] = r.payload_in;
        store_slot = (store_slot + 1) % CAPACITY;
        gen_count = step_gen(gen_count);
      end
      gtjs_pkg::FUNC_LOOKUP: begin
        if (hit) begin
          o.ok = 1'b1;
          o.payload_out = slot_payload[s];
        end
      end
      gtjs_pkg::FUNC_RELEASE: begin
        if (hit) begin
          o.ok = 1'b1;
          slot_live[s] = 1'b0;
        end
      end
      default: begin
        for (int i = 0; i < CAPACITY; i++) begin
          slot_live[i] = 1'b0;
        end
        store_slot = 0;
        gen_count = step_gen(gen_count);
      end
    endcase
    return o;
  endfunction

  task automatic plan_op(input logic [1:0] f, input logic [63:0] pay, input logic [63:0] hdl);
    gtjs_pkg::req_t r;
    r.func = f;
    r.payload_in = pay;
    r.handle_in = hdl;
    job_q.push_back(r);
    planned_ops++;
    if (f == gtjs_pkg::FUNC_STORE) begin
      recent_handles.push_back((plan_gen << GEN_SHIFT) | 64'(plan_slot));
      if (recent_handles.size() > POOL_DEPTH) begin
        void'(recent_handles.pop_front());
      end
      plan_slot = (plan_slot + 1) % CAPACITY;
      plan_gen = step_gen(plan_gen);
    end else if (f == gtjs_pkg::FUNC_INVAL) begin
      plan_slot = 0;
      plan_gen = step_gen(plan_gen);
    end
  endtask

  function automatic logic [63:0] any_recent();
    return recent_handles[$urandom_range(recent_handles.size() - 1)];
  endfunction

  // Handles that look plausible but must miss, plus raw noise
  function automatic logic [63:0] bad_handle();
    logic [63:0] h;
    h = any_recent();
    case ($urandom_range(4))
      0: h = 64'd0;
      1: h = rand64();
      2: h[7:0] = 8'($urandom_range(255, CAPACITY));
      3: h = h ^ (64'd1 << $urandom_range(63));
      default: h[63:GEN_SHIFT] = (64 - GEN_SHIFT)'(rand64());
    endcase
    return h;
  endfunction

  // Driver: a transfer happens at an edge with start high and busy low
  always @(posedge clk) begin
    logic calm;
    if (rst) begin
      start <= 1'b0;
      req <= '0;
    end else begin
      if (start && !busy) begin
        awaited_rsps.push_back(table_op(req));
        accepted_ops++;
      end
      if (!start || !busy) begin
        calm = (accepted_ops > 700) && (accepted_ops < 1100);
        if (job_q.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
          req <= job_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results show for one cycle only
  always @(posedge clk) begin
    gtjs_pkg::rsp_t want;
    if (!rst && done) begin
      if (awaited_rsps.size() == 0) begin
        $error("unexpected result: ok=%0d handle_out=%h payload_out=%h",
               rsp.ok, rsp.handle_out, rsp.payload_out);
        errors++;
      end else begin
        want = awaited_rsps.pop_front();
        if (rsp.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, rsp.ok);
          errors++;
        end
        if (rsp.handle_out !== want.handle_out) begin
          $error("handle_out: expected %h, got %h", want.handle_out, rsp.handle_out);
          errors++;
        end
        if (rsp.payload_out !== want.payload_out) begin
          $error("payload_out: expected %h, got %h", want.payload_out, rsp.payload_out);
          errors++;
        end
      end
    end
  end

  initial begin
    int r;
    // Fill every slot first so no lookup ever touches an unwritten entry
    plan_op(gtjs_pkg::FUNC_STORE, 64'd0, 64'd0);
    plan_op(gtjs_pkg::FUNC_STORE, '1, 64'd0);
    plan_op(gtjs_pkg::FUNC_STORE, 64'h8000_0000_0000_0000, 64'd0);
    plan_op(gtjs_pkg::FUNC_STORE, 64'd1, 64'd0);
    plan_op(gtjs_pkg::FUNC_STORE, 64'h5555_5555_5555_5555, 64'd0);
    plan_op(gtjs_pkg::FUNC_STORE, 64'haaaa_aaaa_aaaa_aaaa, 64'd0);
    for (int i = 6; i < CAPACITY; i++) begin
      plan_op(gtjs_pkg::FUNC_STORE, rand64(), '1);
    end
    plan_op(gtjs_pkg::FUNC_LOOKUP, '1, recent_handles[0]);
    plan_op(gtjs_pkg::FUNC_LOOKUP, 64'd0, recent_handles[15]);
    plan_op(gtjs_pkg::FUNC_LOOKUP, 64'd0, 64'd0);                 // handle zero
    plan_op(gtjs_pkg::FUNC_LOOKUP, 64'd0, {56'd1, 8'hff});        // slot byte out of range
    plan_op(gtjs_pkg::FUNC_RELEASE, 64'd0, {56'd17, 8'(CAPACITY)});
    plan_op(gtjs_pkg::FUNC_LOOKUP, 64'd0, recent_handles[3] ^ 64'h8000_0000_0000_0000);
    plan_op(gtjs_pkg::FUNC_RELEASE, 64'd0, recent_handles[2]);
    plan_op(gtjs_pkg::FUNC_LOOKUP, 64'd0, recent_handles[2]);
    plan_op(gtjs_pkg::FUNC_RELEASE, 64'd0, recent_handles[2]);
    plan_op(gtjs_pkg::FUNC_STORE, rand64(), 64'd0);               // overwrites slot 0
    plan_op(gtjs_pkg::FUNC_LOOKUP, 64'd0, recent_handles[0]);
    plan_op(gtjs_pkg::FUNC_LOOKUP, 64'd0, recent_handles[$]);
    plan_op(gtjs_pkg::FUNC_INVAL, rand64(), rand64());
    plan_op(gtjs_pkg::FUNC_LOOKUP, 64'd0, recent_handles[5]);
    plan_op(gtjs_pkg::FUNC_RELEASE, 64'd0, recent_handles[$]);
    plan_op(gtjs_pkg::FUNC_STORE, rand64(), 64'd0);
    plan_op(gtjs_pkg::FUNC_LOOKUP, 64'd0, recent_handles[$]);

    for (int i = 0; i < RAND_OPS; i++) begin
      r = $urandom_range(99);
      if (r < 36) begin
        plan_op(gtjs_pkg::FUNC_STORE, ($urandom_range(9) == 0) ? '1 : rand64(), rand64());
      end else if (r < 62) begin
        plan_op(gtjs_pkg::FUNC_LOOKUP, rand64(), any_recent());
      end else if (r < 80) begin
        plan_op(gtjs_pkg::FUNC_RELEASE, rand64(), any_recent());
      end else if (r < 83) begin
        plan_op(gtjs_pkg::FUNC_INVAL, rand64(), rand64());
      end else begin
        plan_op($urandom_range(1) ? gtjs_pkg::FUNC_LOOKUP : gtjs_pkg::FUNC_RELEASE,
                rand64(), bad_handle());
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (accepted_ops < planned_ops) @(posedge clk);
    while (awaited_rsps.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
